// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry.
    localparam int WIDTH_DEF  = 80;
    localparam int HEIGHT_DEF = 25;

    // Fixed field widths.
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 12;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_SHOWN = 1'd1;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd3;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Operations handed from the front end to the back end.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PRINT = 3'd0;
    localparam logic [OP_W-1:0] OP_LF    = 3'd1;
    localparam logic [OP_W-1:0] OP_CR    = 3'd2;
    localparam logic [OP_W-1:0] OP_BS    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_SET   = 3'd5;
    localparam logic [OP_W-1:0] OP_DRAW  = 3'd6;
    localparam logic [OP_W-1:0] OP_ERR   = 3'd7;

    // Queue depths; both must be powers of two.
    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic              status;
    } t_res;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_front.sv =====
`timescale 1ns / 1ps

module tcw_front #(
    parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
    parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_hold,
    input  logic [tcw_pkg::KIND_W-1:0]  i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   i_row_in,
    input  logic [tcw_pkg::COL_W-1:0]   i_col_in,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cell_attr_in,
    output logic                        o_cmd_valid,
    output tcw_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);

    localparam int PTR_W = (tcw_pkg::CMDQ_DEPTH > 1) ? $clog2(tcw_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(tcw_pkg::CMDQ_DEPTH + 1);

    tcw_pkg::t_cmd          r_q [tcw_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]       r_wptr;
    logic [PTR_W-1:0]       r_rptr;
    logic [CNT_W-1:0]       r_cnt;
    tcw_pkg::t_cmd          cls;
    logic                   in_range;
    logic                   accept;

    assign in_range = ({1'b0, i_row_in} < (tcw_pkg::ROW_W + 1)'(HEIGHT))
                   && ({1'b0, i_col_in} < (tcw_pkg::COL_W + 1)'(WIDTH));

    // Each word is decoded into one back-end operation as it enters.
    always_comb begin
        cls.ch   = i_char_code;
        cls.attr = i_cell_attr_in;
        cls.row  = i_row_in;
        cls.col  = i_col_in;
        cls.op   = tcw_pkg::OP_ERR;
        if (i_kind == tcw_pkg::KIND_PUT) begin
            unique case (i_char_code)
                tcw_pkg::CH_LF: cls.op = tcw_pkg::OP_LF;
                tcw_pkg::CH_CR: cls.op = tcw_pkg::OP_CR;
                tcw_pkg::CH_BS: cls.op = tcw_pkg::OP_BS;
                default:        cls.op = tcw_pkg::OP_PRINT;
            endcase
        end else if (in_range) begin
            unique case (i_kind)
                tcw_pkg::KIND_READ: cls.op = tcw_pkg::OP_READ;
                tcw_pkg::KIND_SET:  cls.op = tcw_pkg::OP_SET;
                default:            cls.op = tcw_pkg::OP_DRAW;
            endcase
        end
    end

    assign full        = (r_cnt == CNT_W'(tcw_pkg::CMDQ_DEPTH)) || i_hold;
    assign accept      = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (accept && !i_cmd_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!accept && i_cmd_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
`timescale 1ns / 1ps

module tcw_back #(
    parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
    parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cfg_data,
    input  logic                           i_cmd_valid,
    input  tcw_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_hold,
    output logic                           empty,
    input  logic                           pop,
    output tcw_pkg::t_res                  o_res
);

    localparam int CELLS      = WIDTH * HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int HIDDEN_POS = HEIGHT * WIDTH + WIDTH + 1;
    localparam int RPTR_W     = (tcw_pkg::RESQ_DEPTH > 1) ? $clog2(tcw_pkg::RESQ_DEPTH) : 1;
    localparam int RCNT_W     = $clog2(tcw_pkg::RESQ_DEPTH + 1);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [tcw_pkg::ROW_W-1:0]    r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]    r_col, n_col;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr;
    logic                         r_shown;
    logic                         r_is_read, n_is_read;
    logic                         r_err, n_err;

    tcw_pkg::t_res                r_resq [tcw_pkg::RESQ_DEPTH];
    logic [RPTR_W-1:0]            r_res_wptr;
    logic [RPTR_W-1:0]            r_res_rptr;
    logic [RCNT_W-1:0]            r_res_cnt;
    logic                         res_push;
    logic                         res_pop;
    tcw_pkg::t_res                res_new;

    logic                         take;
    logic                         at_right;
    logic                         at_bottom;
    logic [tcw_pkg::ROW_W-1:0]    bs_row, a_row;
    logic [tcw_pkg::COL_W-1:0]    bs_col, a_col;
    logic [tcw_pkg::POS_W-1:0]    a_lin;
    logic [tcw_pkg::POS_W-1:0]    cur_lin;
    logic [CNT_W-1:0]             cnt_m1;
    logic [CNT_W-1:0]             cnt_src;

    logic                         mem_we, mem_re;
    logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata, mem_rdata;

    tcw_ram #(
        .DATA_W (tcw_pkg::CELL_W),
        .DEPTH  (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign take      = (r_state == S_IDLE) && i_cmd_valid
                    && (r_res_cnt != RCNT_W'(tcw_pkg::RESQ_DEPTH));
    assign o_cmd_pop = take;
    assign o_hold    = (r_state == S_CLEAR);
    assign at_right  = (r_col == tcw_pkg::COL_W'(WIDTH - 1));
    assign at_bottom = (r_row == tcw_pkg::ROW_W'(HEIGHT - 1));

    // Backspace at home stays at home.
    always_comb begin
        bs_row = r_row;
        bs_col = r_col;
        if (r_col != '0) begin
            bs_col = r_col - 1'b1;
        end else if (r_row != '0) begin
            bs_row = r_row - 1'b1;
            bs_col = tcw_pkg::COL_W'(WIDTH - 1);
        end
    end

    always_comb begin
        unique case (i_cmd.op) inside
            tcw_pkg::OP_READ, tcw_pkg::OP_DRAW: begin
                a_row = i_cmd.row;
                a_col = i_cmd.col;
            end
            tcw_pkg::OP_BS: begin
                a_row = bs_row;
                a_col = bs_col;
            end
            default: begin
                a_row = r_row;
                a_col = r_col;
            end
        endcase
    end

    assign a_lin   = tcw_pkg::POS_W'(a_row) * tcw_pkg::POS_W'(WIDTH) + tcw_pkg::POS_W'(a_col);
    assign cur_lin = tcw_pkg::POS_W'(r_row) * tcw_pkg::POS_W'(WIDTH) + tcw_pkg::POS_W'(r_col);
    assign cnt_m1  = r_cnt - 1'b1;
    assign cnt_src = r_cnt + CNT_W'(WIDTH);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_row     = r_row;
        n_col     = r_col;
        n_is_read = r_is_read;
        n_err     = r_err;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = a_lin[ADDR_W-1:0];
        mem_raddr = a_lin[ADDR_W-1:0];
        mem_wdata = {r_attr, i_cmd.ch};
        res_push  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[ADDR_W-1:0];
                mem_wdata = {tcw_pkg::ATTR_W'(0), tcw_pkg::CH_SPACE};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    n_is_read = 1'b0;
                    n_err     = 1'b0;
                    n_state   = S_DONE;
                    n_cnt     = '0;
                    unique case (i_cmd.op)
                        tcw_pkg::OP_PRINT: begin
                            mem_we = 1'b1;
                            if (at_right) begin
                                n_col = '0;
                                if (at_bottom) begin
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcw_pkg::OP_LF: begin
                            n_col = '0;
                            if (at_bottom) begin
                                n_state = S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        tcw_pkg::OP_CR: begin
                            n_col = '0;
                        end
                        tcw_pkg::OP_BS: begin
                            mem_we    = 1'b1;
                            mem_wdata = {r_attr, tcw_pkg::CH_SPACE};
                            n_row     = bs_row;
                            n_col     = bs_col;
                        end
                        tcw_pkg::OP_READ: begin
                            mem_re    = 1'b1;
                            n_is_read = 1'b1;
                        end
                        tcw_pkg::OP_SET: begin
                            n_row = i_cmd.row;
                            n_col = i_cmd.col;
                        end
                        tcw_pkg::OP_DRAW: begin
                            mem_we    = 1'b1;
                            mem_wdata = {i_cmd.attr, i_cmd.ch};
                        end
                        default: begin
                            n_err = 1'b1;
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                // Read runs one cell ahead of the write; the last row is filled with zero.
                mem_raddr = cnt_src[ADDR_W-1:0];
                mem_re    = (r_cnt < CNT_W'(CELLS - WIDTH));
                mem_waddr = cnt_m1[ADDR_W-1:0];
                mem_we    = (r_cnt != '0);
                mem_wdata = (r_cnt <= CNT_W'(CELLS - WIDTH)) ? mem_rdata : '0;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CELLS)) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                res_push = 1'b1;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res_new.row    = r_row;
        res_new.col    = r_col;
        res_new.pos    = r_shown ? cur_lin : tcw_pkg::POS_W'(HIDDEN_POS);
        res_new.ch     = r_is_read ? mem_rdata[tcw_pkg::CHAR_W-1:0] : '0;
        res_new.attr   = r_is_read ? mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
        res_new.status = r_err;
    end

    assign empty   = (r_res_cnt == '0);
    assign res_pop = pop && !empty;
    assign o_res   = r_resq[r_res_rptr];

    always_ff @(posedge i_clk) begin
        r_is_read <= n_is_read;
        r_err     <= n_err;
        if (res_push) begin
            r_resq[r_res_wptr] <= res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_attr     <= '0;
            r_shown    <= 1'b1;
            r_res_wptr <= '0;
            r_res_rptr <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcw_pkg::CFG_TEXT_ATTR: r_attr  <= i_cfg_data;
                    default:                r_shown <= i_cfg_data[0];
                endcase
            end
            if (res_push) begin
                r_res_wptr <= r_res_wptr + 1'b1;
            end
            if (res_pop) begin
                r_res_rptr <= r_res_rptr + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end else if (!res_push && res_pop) begin
                r_res_cnt <= r_res_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
`timescale 1ns / 1ps

// A pushed word goes through the front end's command queue, the back end's execute step
// and its result step; the back end takes no new word before that result step is done,
// nor while the result queue is full. A line feed or wrap on the bottom row scrolls the
// screen, one cell per cycle through the single write port of the cell memory.
// Reset: after reset, full stays high while the cell memory is cleared to spaces;
// configuration writes are taken throughout.
module text_console_writer #(
    parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
    parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [tcw_pkg::KIND_W-1:0]     i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]      i_row_in,
    input  logic [tcw_pkg::COL_W-1:0]      i_col_in,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cell_attr_in,
    output logic                           empty,
    input  logic                           pop,
    output logic [tcw_pkg::ROW_W-1:0]      o_row_now,
    output logic [tcw_pkg::COL_W-1:0]      o_col_now,
    output logic [tcw_pkg::POS_W-1:0]      o_crtc_position,
    output logic [tcw_pkg::CHAR_W-1:0]     o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]     o_cell_attr,
    output logic                           o_status
);

    logic           cmd_valid;
    logic           cmd_pop;
    logic           hold;
    tcw_pkg::t_cmd  cmd;
    tcw_pkg::t_res  res;

    tcw_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_hold         (hold),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_row_in       (i_row_in),
        .i_col_in       (i_col_in),
        .i_cell_attr_in (i_cell_attr_in),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    tcw_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_hold      (hold),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res)
    );

    assign o_row_now       = res.row;
    assign o_col_now       = res.col;
    assign o_crtc_position = res.pos;
    assign o_cell_char     = res.ch;
    assign o_cell_attr     = res.attr;
    assign o_status        = res.status;

endmodule
